### src/osq_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the sorted open-set queue
// no dependencies

package osq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } osq_op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } osq_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_PUT,
        S_FIN
    } osq_state_t;

    // one stored entry, as it sits in the ram word
    typedef struct packed {
        logic [15:0]        id;
        logic [31:0]        cost;
        logic signed [31:0] lat;
        logic signed [31:0] lon;
    } osq_entry_t;

    // one operation handed to the engine
    typedef struct packed {
        osq_op_t    op;
        osq_entry_t ent;
    } osq_cmd_t;

    // finished result held by the engine (count travels separately)
    typedef struct packed {
        osq_status_t status;
        logic        found;
        logic [15:0] found_id;
        logic        head_valid;
        logic [15:0] head_id;
        logic [31:0] head_cost;
    } osq_res_t;

endpackage

### src/osq_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module osq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/osq_engine.sv
`timescale 1ns / 1ps
// sequencer that scans and shifts the sorted list held in the entry ram
// depends on osq_pkg and osq_ram

module osq_engine #(
    parameter int CAPACITY = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  osq_pkg::osq_cmd_t                 cmd,
    output logic                              ready,
    output logic                              done,
    input  logic                              take,
    output osq_pkg::osq_res_t                 res,
    output logic [$clog2(CAPACITY+1)-1:0]     count
);
    import osq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = $bits(osq_entry_t);

    osq_state_t  state_reg, state_next;
    osq_op_t     op_reg, op_next;
    osq_entry_t  new_reg, new_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic        hit_reg, hit_next;
    osq_status_t status_reg, status_next;
    logic        found_reg, found_next;
    logic [15:0] found_id_reg, found_id_next;
    logic [15:0] head_id_reg, head_id_next;
    logic [31:0] head_cost_reg, head_cost_next;

    logic          we;
    logic [AW-1:0] waddr;
    osq_entry_t    wdata;
    logic [AW-1:0] raddr;
    logic [EW-1:0] rword;
    osq_entry_t    rdata;
    logic          last;
    logic          id_match;

    assign rdata    = osq_entry_t'(rword);
    assign raddr    = idx_reg[AW-1:0];
    assign last     = (idx_reg == (count_reg - CW'(1)));
    assign id_match = (rdata.id == new_reg.id);

    osq_ram #(
        .WIDTH(EW),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rword)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    priority if (cmd.op == OP_CLEAR || count_reg == '0)
                        state_next = S_FIN;
                    else if (cmd.op == OP_INSERT && count_reg == CW'(CAPACITY))
                        state_next = S_FIN;
                    else
                        state_next = S_READ;
                end
            end
            S_READ: state_next = S_EVAL;
            S_EVAL:
            begin
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        priority if (rdata.cost <= new_reg.cost)
                            state_next = S_FIN;
                        else if (idx_reg == '0)
                            state_next = S_PUT;
                        else
                            state_next = S_READ;
                    end
                    OP_LOOKUP:
                    begin
                        if (((rdata.lat == new_reg.lat) && (rdata.lon == new_reg.lon)) || last)
                            state_next = S_FIN;
                        else
                            state_next = S_READ;
                    end
                    default:
                    begin
                        state_next = last ? S_FIN : S_READ;
                    end
                endcase
            end
            S_PUT: state_next = S_FIN;
            S_FIN:
            begin
                if (take)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        op_next        = op_reg;
        new_next       = new_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        hit_next       = hit_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        found_id_next  = found_id_reg;
        head_id_next   = head_id_reg;
        head_cost_next = head_cost_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = new_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next       = cmd.op;
                    new_next      = cmd.ent;
                    hit_next      = 1'b0;
                    status_next   = ST_OK;
                    found_next    = 1'b0;
                    found_id_next = '0;
                    idx_next      = (cmd.op == OP_INSERT) ? (count_reg - CW'(1)) : '0;
                    unique case (cmd.op)
                        OP_CLEAR: count_next = '0;
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                                status_next = ST_NOTFOUND;
                        end
                        OP_INSERT:
                        begin
                            priority if (count_reg == CW'(CAPACITY))
                                status_next = ST_FULL;
                            else if (count_reg == '0)
                            begin
                                // empty list: new entry becomes the head
                                we             = 1'b1;
                                waddr          = '0;
                                wdata          = cmd.ent;
                                head_id_next   = cmd.ent.id;
                                head_cost_next = cmd.ent.cost;
                                count_next     = count_reg + CW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_EVAL:
            begin
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        we = 1'b1;
                        waddr = AW'(idx_reg + CW'(1));
                        if (rdata.cost <= new_reg.cost)
                        begin
                            // slot found above this entry
                            wdata      = new_reg;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            // move entry one place towards the tail
                            wdata    = rdata;
                            idx_next = idx_reg - CW'(1);
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            // close the gap left by the removed entry
                            we    = 1'b1;
                            waddr = AW'(idx_reg - CW'(1));
                            wdata = rdata;
                            if (idx_reg == CW'(1))
                            begin
                                head_id_next   = rdata.id;
                                head_cost_next = rdata.cost;
                            end
                        end
                        else if (id_match)
                        begin
                            hit_next = 1'b1;
                        end
                        if (last)
                        begin
                            if (hit_reg || id_match)
                                count_next = count_reg - CW'(1);
                            else
                                status_next = ST_NOTFOUND;
                        end
                        idx_next = idx_reg + CW'(1);
                    end
                    OP_LOOKUP:
                    begin
                        if ((rdata.lat == new_reg.lat) && (rdata.lon == new_reg.lon))
                        begin
                            found_next    = 1'b1;
                            found_id_next = rdata.id;
                        end
                        idx_next = idx_reg + CW'(1);
                    end
                    default: ;
                endcase
            end
            S_PUT:
            begin
                // new lowest cost entry goes to the head
                we             = 1'b1;
                waddr          = '0;
                wdata          = new_reg;
                head_id_next   = new_reg.id;
                head_cost_next = new_reg.cost;
                count_next     = count_reg + CW'(1);
            end
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        new_reg       <= new_next;
        idx_reg       <= idx_next;
        hit_reg       <= hit_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        found_id_reg  <= found_id_next;
        head_id_reg   <= head_id_next;
        head_cost_reg <= head_cost_next;
    end

    // outputs
    always_comb
    begin
        ready          = (state_reg == S_IDLE);
        done           = (state_reg == S_FIN);
        count          = count_reg;
        res.status     = status_reg;
        res.found      = found_reg;
        res.found_id   = found_id_reg;
        res.head_valid = (count_reg != '0);
        res.head_id    = (count_reg != '0) ? head_id_reg : '0;
        res.head_cost  = (count_reg != '0) ? head_cost_reg : '0;
    end

endmodule

### src/sorted_open_set_queue_top.sv
`timescale 1ns / 1ps
// top level of the sorted open-set queue: handshakes and result register
// depends on osq_pkg and osq_engine

// Sorted open-set queue. Entries live in one ram, sorted by cost, lowest
// first; each item runs through a sequencer that reads entries through the
// registered ram read port and writes back shifted entries. Insert scans from
// the tail over the entries with higher cost, moving each one place towards
// the tail, and writes the new entry at the head when it has the lowest cost;
// an insert into an empty list writes the entry at the head directly. Remove
// always scans the whole list; lookup scans up to the match. Clear, refused
// inserts and operations on an empty list skip the scan. A result stalled at
// the output holds the sequencer until the output register takes it. A new
// item is taken while the previous result still waits in the output register.
// No clearing pass after reset.

module sorted_open_set_queue_top #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    operation,
    input  logic [15:0]                   node_id,
    input  logic [31:0]                   cost,
    input  logic signed [31:0]            latitude,
    input  logic signed [31:0]            longitude,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic                          found,
    output logic [15:0]                   found_id,
    output logic                          head_valid,
    output logic [15:0]                   head_id,
    output logic [31:0]                   head_cost,
    output logic [$clog2(CAPACITY+1)-1:0] entry_count
);
    import osq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    osq_cmd_t      cmd;
    osq_res_t      res;
    logic [CW-1:0] eng_count;
    logic          eng_ready;
    logic          eng_done;
    logic          take;
    logic          out_valid_reg, out_valid_next;
    osq_res_t      res_reg;
    logic [CW-1:0] count_reg;

    // incoming item
    always_comb
    begin
        cmd.op      = osq_op_t'(operation);
        cmd.ent.id  = node_id;
        cmd.ent.cost = cost;
        cmd.ent.lat = latitude;
        cmd.ent.lon = longitude;
    end

    assign in_stall = !eng_ready;
    assign take     = eng_done && (!out_valid_reg || !out_stall);

    osq_engine #(
        .CAPACITY(CAPACITY)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_valid && eng_ready),
        .cmd   (cmd),
        .ready (eng_ready),
        .done  (eng_done),
        .take  (take),
        .res   (res),
        .count (eng_count)
    );

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg   <= res;
            count_reg <= eng_count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = res_reg.status;
    assign found       = res_reg.found;
    assign found_id    = res_reg.found_id;
    assign head_valid  = res_reg.head_valid;
    assign head_id     = res_reg.head_id;
    assign head_cost   = res_reg.head_cost;
    assign entry_count = count_reg;

endmodule

### src/osq_checker.sv
`timescale 1ns / 1ps
// port level checks on the sorted open-set queue, bound to the top level
// depends on osq_pkg and sorted_open_set_queue_top

module osq_checker #(
    parameter int CAPACITY = 64
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    status,
    input logic                          found,
    input logic [15:0]                   found_id,
    input logic                          head_valid,
    input logic [$clog2(CAPACITY+1)-1:0] entry_count
);
    import osq_pkg::*;

    // head flag agrees with the count
    a_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (head_valid == (entry_count != '0)))
        else $error("head_valid disagrees with entry_count");

    // refused insert only when full
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (entry_count == ($clog2(CAPACITY+1))'(CAPACITY)))
        else $error("insert refused while not full");

    // no id reported without a match
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (found_id == '0))
        else $error("found_id set without a match");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(entry_count) && $stable(status)))
        else $error("stalled item changed");

endmodule

bind sorted_open_set_queue_top osq_checker #(.CAPACITY(CAPACITY)) u_osq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found       (found),
    .found_id    (found_id),
    .head_valid  (head_valid),
    .entry_count (entry_count)
);

### sim/tb_sorted_open_set_queue_top.sv
`timescale 1ns / 1ps
// testbench for the sorted open-set queue: directed and random operations
// checked against a cost-sorted list predictor; depends on osq_pkg and the top level

module tb_sorted_open_set_queue_top;
    import osq_pkg::*;

    localparam int CAP = 64;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [1:0]  status;
        logic        found;
        logic [15:0] found_id;
        logic        head_valid;
        logic [15:0] head_id;
        logic [31:0] head_cost;
        logic [6:0]  entry_count;
    } osq_result_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          operation;
    logic [15:0]         node_id;
    logic [31:0]         cost;
    logic signed [31:0]  latitude;
    logic signed [31:0]  longitude;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          status;
    logic                found;
    logic [15:0]         found_id;
    logic                head_valid;
    logic [15:0]         head_id;
    logic [31:0]         head_cost;
    logic [6:0]          entry_count;

    // predictor copy of the list
    logic [15:0]         list_id[$];
    logic [31:0]         list_cost[$];
    logic [31:0]         list_lat[$];
    logic [31:0]         list_lon[$];
    osq_result_t         pending_results[$];

    int                  fail_count;
    int                  cycle_count;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  hold_cycles;

    sorted_open_set_queue_top #(.CAPACITY(CAP)) u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .node_id(node_id), .cost(cost),
        .latitude(latitude), .longitude(longitude), .out_valid(out_valid),
        .out_stall(out_stall), .status(status), .found(found),
        .found_id(found_id), .head_valid(head_valid), .head_id(head_id),
        .head_cost(head_cost), .entry_count(entry_count)
    );

    // clock
    always #10 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL sorted_open_set_queue_top");
            $finish;
        end
    end

    // receiver stall, random or a long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // predict the result of one operation and update the list
    function automatic osq_result_t apply_operation(logic [1:0] op, logic [15:0] id,
        logic [31:0] key, logic [31:0] lat, logic [31:0] lon);
        osq_result_t r;
        int          pos;
        r = '{default: '0};
        unique case (op)
            OP_INSERT:
            begin
                if (list_id.size() >= CAP)
                    r.status = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < list_id.size() && list_cost[pos] <= key)
                        pos++;
                    list_id.insert(pos, id);
                    list_cost.insert(pos, key);
                    list_lat.insert(pos, lat);
                    list_lon.insert(pos, lon);
                end
            end
            OP_REMOVE:
            begin
                pos = 0;
                while (pos < list_id.size() && list_id[pos] != id)
                    pos++;
                if (pos >= list_id.size())
                    r.status = ST_NOTFOUND;
                else
                begin
                    list_id.delete(pos);
                    list_cost.delete(pos);
                    list_lat.delete(pos);
                    list_lon.delete(pos);
                end
            end
            OP_LOOKUP:
            begin
                for (pos = 0; pos < list_id.size(); pos++)
                begin
                    if (list_lat[pos] == lat && list_lon[pos] == lon)
                    begin
                        r.found = 1'b1;
                        r.found_id = list_id[pos];
                        break;
                    end
                end
            end
            default:
            begin
                list_id.delete();
                list_cost.delete();
                list_lat.delete();
                list_lon.delete();
            end
        endcase
        if (list_id.size() > 0)
        begin
            r.head_valid = 1'b1;
            r.head_id = list_id[0];
            r.head_cost = list_cost[0];
        end
        r.entry_count = 7'(list_id.size());
        return r;
    endfunction

    // offer one item until accepted, then predict it
    task automatic send_item(logic [1:0] op, logic [15:0] id, logic [31:0] key,
        logic [31:0] lat, logic [31:0] lon);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        node_id <= id;
        cost <= key;
        latitude <= lat;
        longitude <= lon;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(apply_operation(op, id, key, lat, lon));
    endtask

    // check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        osq_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item");
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, status);
                    fail_count++;
                end
                if (found !== e.found)
                begin
                    $error("found expected %0d actual %0d", e.found, found);
                    fail_count++;
                end
                if (found_id !== e.found_id)
                begin
                    $error("found_id expected %0d actual %0d", e.found_id, found_id);
                    fail_count++;
                end
                if (head_valid !== e.head_valid)
                begin
                    $error("head_valid expected %0d actual %0d", e.head_valid, head_valid);
                    fail_count++;
                end
                if (head_id !== e.head_id)
                begin
                    $error("head_id expected %0d actual %0d", e.head_id, head_id);
                    fail_count++;
                end
                if (head_cost !== e.head_cost)
                begin
                    $error("head_cost expected %0d actual %0d", e.head_cost, head_cost);
                    fail_count++;
                end
                if (entry_count !== e.entry_count)
                begin
                    $error("entry_count expected %0d actual %0d", e.entry_count,
                        entry_count);
                    fail_count++;
                end
            end
        end
    end

    // extremes, every operation, duplicates, equal costs, full and empty lists
    task automatic test_directed();
        send_item(OP_REMOVE, 16'd5, 32'd0, 32'd0, 32'd0);
        send_item(OP_LOOKUP, 16'd0, 32'd0, 32'd0, 32'd0);
        send_item(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_INSERT, 16'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_INSERT, 16'd7, 32'd100, 32'd1, 32'd2);
        send_item(OP_INSERT, 16'd8, 32'd100, 32'd1, 32'd2);
        send_item(OP_INSERT, 16'd7, 32'd50, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_LOOKUP, 16'd0, 32'd0, 32'd1, 32'd2);
        send_item(OP_LOOKUP, 16'd0, 32'd0, 32'd1, 32'd3);
        send_item(OP_LOOKUP, 16'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_REMOVE, 16'd7, 32'd0, 32'd0, 32'd0);
        send_item(OP_REMOVE, 16'd0, 32'd0, 32'd0, 32'd0);
        send_item(OP_REMOVE, 16'd1234, 32'd0, 32'd0, 32'd0);
        send_item(OP_CLEAR, 16'd0, 32'd0, 32'd0, 32'd0);
        send_item(OP_CLEAR, 16'd0, 32'd0, 32'd0, 32'd0);
        // fill past capacity
        for (int i = 0; i < CAP + 2; i++)
            send_item(OP_INSERT, 16'(i), 32'($urandom_range(20)), 32'(i), 32'd0);
        send_item(OP_REMOVE, 16'd3, 32'd0, 32'd0, 32'd0);
        send_item(OP_CLEAR, 16'd0, 32'd0, 32'd0, 32'd0);
    endtask

    // random mix with small id and coordinate pools so matches happen
    task automatic test_random(int n_items);
        int          pick;
        logic [1:0]  op;
        logic [15:0] id;
        logic [31:0] key;
        logic [31:0] lat;
        logic [31:0] lon;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                op = OP_INSERT;
            else if (pick < 72)
                op = OP_REMOVE;
            else if (pick < 97)
                op = OP_LOOKUP;
            else
                op = OP_CLEAR;
            id = 16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(31));
            key = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
            lat = ($urandom_range(3) == 0) ? $urandom : $urandom_range(7);
            lon = ($urandom_range(3) == 0) ? $urandom : $urandom_range(7);
            send_item(op, id, key, lat, lon);
        end
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        hold_cycles = 600;
        test_random(40);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        operation = '0;
        node_id = '0;
        cost = '0;
        latitude = '0;
        longitude = '0;
        fail_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        send_idle_pct = 34;
        recv_idle_pct = 51;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(420);
        send_idle_pct = 51;
        recv_idle_pct = 34;
        test_random(420);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(330);
        wait_drained();

        if (fail_count == 0)
            $display("PASS sorted_open_set_queue_top");
        else
            $display("FAIL sorted_open_set_queue_top");
        $finish;
    end

endmodule

### filelist.f
src/osq_pkg.sv
src/osq_ram.sv
src/osq_engine.sv
src/sorted_open_set_queue_top.sv
src/osq_checker.sv
sim/tb_sorted_open_set_queue_top.sv
